>>> sv/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants for the alpha compositor
// Holds the channel constants, the divider width and the record that one
// pipeline cell hands to its neighbor.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int ChanW = 8;
  localparam int NumW  = 17;               // s*sa + d*da*inv/255 < 2^17
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [1:0] {
    MODE_BLEND  = 2'd0,
    MODE_PASS_D = 2'd1,
    MODE_PASS_S = 2'd2
  } mode_t;

  // Data carried from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic [31:0]       pass_px;
    logic [ChanW-1:0]  oa;
    logic [NumW-1:0]   rem_r;
    logic [NumW-1:0]   rem_g;
    logic [NumW-1:0]   rem_b;
    logic [NumW-1:0]   quo_r;
    logic [NumW-1:0]   quo_g;
    logic [NumW-1:0]   quo_b;
  } cell_t;

  // Truncating division by 255 for values below 255*256 (da*inv and d*r fit).
  function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    begin
      t = {1'b0, x} + 17'd1;
      t = t + {9'd0, t[15:8]};
      div255 = t[15:8];
    end
  endfunction

endpackage

>>> sv/pac_front.sv
// ----------------------------------------------------------------------------
// pac_front: product stages
// Splits the pixels, forms output alpha and the three colour numerators.
// ----------------------------------------------------------------------------
module pac_front import pac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] src_argb,
  input  logic [31:0] dst_argb,
  output cell_t       cell_out
);

  logic [7:0]  sa, da, inv;
  logic [15:0] dainv;
  logic [7:0]  w0, rem0;
  cell_t       cell_next;

  // First stage registers: split pixels, alpha weight and remainder.
  logic        v1;
  mode_t       mode1;
  logic [31:0] px1;
  logic [7:0]  sa1, w1, rem1;
  logic [7:0]  s1 [3];
  logic [7:0]  d1 [3];

  assign sa  = src_argb[31:24];
  assign da  = dst_argb[31:24];
  assign inv = ChanMax - sa;
  assign dainv = da * inv;
  assign w0 = div255(dainv);
  // The remainder dainv - 255*w0 lies in 0..254, so its low eight bits
  // equal dainv + w0 taken modulo 256.
  assign rem0 = dainv[7:0] + w0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    sa1  <= sa;
    w1   <= w0;
    rem1 <= rem0;
    px1 <= (sa == 8'd0) ? dst_argb : (src_argb | 32'hFF00_0000);
    if (sa == 8'd0) begin
      mode1 <= MODE_PASS_D;
    end else if (sa == ChanMax) begin
      mode1 <= MODE_PASS_S;
    end else begin
      mode1 <= MODE_BLEND;
    end
    for (int i = 0; i < 3; i++) begin
      s1[i] <= src_argb[8*i +: 8];
      d1[i] <= dst_argb[8*i +: 8];
    end
  end

  // With da*inv = 255*w + r, floor(d*da*inv/255) = d*w + floor(d*r/255),
  // and d*r stays below 2^16 so the short divide-by-255 is exact.
  function automatic logic [NumW-1:0] num_of(input logic [7:0] s, input logic [7:0] d,
                                             input logic [7:0] a, input logic [7:0] w,
                                             input logic [7:0] r);
    logic [15:0] dw;
    logic [15:0] dr;
    logic [15:0] sp;
    begin
      dw = d * w;
      dr = d * r;
      sp = s * a;
      num_of = {1'b0, sp} + {1'b0, dw} + {9'd0, div255(dr)};
    end
  endfunction

  always_comb begin
    cell_next        = '0;
    cell_next.valid  = v1;
    cell_next.mode   = mode1;
    cell_next.pass_px = px1;
    cell_next.oa     = sa1 + w1;
    cell_next.quo_b  = num_of(s1[0], d1[0], sa1, w1, rem1);
    cell_next.quo_g  = num_of(s1[1], d1[1], sa1, w1, rem1);
    cell_next.quo_r  = num_of(s1[2], d1[2], sa1, w1, rem1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= cell_next.valid;
    end
    cell_out.mode    <= cell_next.mode;
    cell_out.pass_px <= cell_next.pass_px;
    cell_out.oa      <= cell_next.oa;
    cell_out.rem_r   <= '0;
    cell_out.rem_g   <= '0;
    cell_out.rem_b   <= '0;
    cell_out.quo_r   <= cell_next.quo_r;
    cell_out.quo_g   <= cell_next.quo_g;
    cell_out.quo_b   <= cell_next.quo_b;
  end

endmodule

>>> sv/pac_div_cell.sv
// ----------------------------------------------------------------------------
// pac_div_cell: one restoring division step
// Shifts one numerator bit into each partial remainder and subtracts oa where it fits.
// ----------------------------------------------------------------------------
module pac_div_cell import pac_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t cell_in,
  output cell_t cell_out
);

  cell_t c;

  function automatic logic [2*NumW:0] step(input logic [NumW-1:0] rem,
                                           input logic [NumW-1:0] quo,
                                           input logic [ChanW-1:0] oa);
    logic [NumW-1:0] r;
    logic            bit_q;
    begin
      r = {rem[NumW-2:0], quo[NumW-1]};
      bit_q = (r >= {9'd0, oa});
      if (bit_q) begin
        r = r - {9'd0, oa};
      end
      step = {r, quo[NumW-2:0], bit_q, 1'b0};
    end
  endfunction

  logic [2*NumW:0] sr, sg, sb;

  always_comb begin
    sr = step(cell_in.rem_r, cell_in.quo_r, cell_in.oa);
    sg = step(cell_in.rem_g, cell_in.quo_g, cell_in.oa);
    sb = step(cell_in.rem_b, cell_in.quo_b, cell_in.oa);
    c = cell_in;
    c.rem_r = sr[2*NumW -: NumW];
    c.quo_r = sr[NumW:1];
    c.rem_g = sg[2*NumW -: NumW];
    c.quo_g = sg[NumW:1];
    c.rem_b = sb[2*NumW -: NumW];
    c.quo_b = sb[NumW:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else begin
      cell_out.valid <= c.valid;
    end
    cell_out.mode    <= c.mode;
    cell_out.pass_px <= c.pass_px;
    cell_out.oa      <= c.oa;
    cell_out.rem_r   <= c.rem_r;
    cell_out.rem_g   <= c.rem_g;
    cell_out.rem_b   <= c.rem_b;
    cell_out.quo_r   <= c.quo_r;
    cell_out.quo_g   <= c.quo_g;
    cell_out.quo_b   <= c.quo_b;
  end

endmodule

>>> sv/pixel_alpha_composite.sv
// ----------------------------------------------------------------------------
// pixel_alpha_composite: source-over-destination with straight alpha
// Two product stages feed a row of seventeen divider cells and an output
// register.
// ----------------------------------------------------------------------------
// One pixel pair is taken on every clock where start is high; busy never
// rises, so the block takes one item per cycle with no gaps. Each result
// appears on out_argb with done high for a single cycle. The twenty register
// stages are two product stages, one division cell per quotient bit
// (seventeen), and one output register. The receiver cannot stall, so
// results must be taken as they come. A source alpha of zero passes the
// destination through; a source alpha of 255 passes the source with opaque
// alpha; colour results wrap to their low eight bits.
module pixel_alpha_composite import pac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] src_argb,
  input  logic [31:0] dst_argb,
  output logic        done,
  output logic [31:0] out_argb
);

  cell_t chain [NumW+1];

  assign busy = 1'b0;

  pac_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .src_argb (src_argb),
    .dst_argb (dst_argb),
    .cell_out (chain[0])
  );

  // Each cell resolves one quotient bit, most significant first.
  for (genvar k = 0; k < NumW; k++) begin : g_cell
    pac_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  cell_t last;
  assign last = chain[NumW];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    if (last.mode == MODE_BLEND) begin
      out_argb <= {last.oa, last.quo_r[7:0], last.quo_g[7:0], last.quo_b[7:0]};
    end else begin
      out_argb <= last.pass_px;
    end
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    chain[0].valid |-> ##18 done)
    else $error("result not produced after fixed latency");
  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_oa_nonzero: assert property (@(posedge clk) disable iff (rst)
    (chain[0].valid && chain[0].mode == MODE_BLEND) |-> chain[0].oa != 8'd0)
    else $error("zero output alpha on blend path");
`endif

endmodule
